@@ sv/rde_pkg.sv @@
// ----------------------------------------------------------------------------
// rde_pkg
// Command and result codes, and the store control group, shared by the
// reversible deque engine modules.
// ----------------------------------------------------------------------------
package rde_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_REVERSE = 2'd1,
      CMD_DELETE  = 2'd2,
      CMD_FINISH  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ELEMENT = 2'd0,
      KIND_ERROR   = 2'd1,
      KIND_EMPTY   = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

@@ sv/rde_store.sv @@
// ----------------------------------------------------------------------------
// rde_store
// Element memory: one write port, one read port and registered read data.
// ----------------------------------------------------------------------------
module rde_store #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 8,
   localparam int AW        = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  rde_pkg::mem_ctl_type    mem_ctl,
   input  logic [AW-1:0]           wr_addr,
   input  logic [VALUE_BITS-1:0]   wr_data,
   input  logic [AW-1:0]           rd_addr,
   output logic [VALUE_BITS-1:0]   rd_data
);

   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rde_ctrl.sv @@
// ----------------------------------------------------------------------------
// rde_ctrl
// Command sequencer: head/count pointers, direction and error flags,
// finish streaming from the store and the result register.
// ----------------------------------------------------------------------------
module rde_ctrl #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 8,
   localparam int AW        = $clog2(DEPTH),
   localparam int CW        = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic [VALUE_BITS-1:0]   req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [VALUE_BITS-1:0]   rsp_element,
   output logic [1:0]              rsp_kind,
   output logic                    rsp_last,
   output rde_pkg::mem_ctl_type    mem_ctl,
   output logic [AW-1:0]           wr_addr,
   output logic [VALUE_BITS-1:0]   wr_data,
   output logic [AW-1:0]           rd_addr,
   input  logic [VALUE_BITS-1:0]   rd_data
);

   typedef enum logic {
      ST_IDLE,
      ST_STREAM
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic                  err_ff, err_in;
   logic [CW-1:0]         issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic                  pend_last_ff, pend_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_element_ff, rsp_element_in;
   rde_pkg::kind_type     rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  accept;
   rde_pkg::cmd_type      cmd;
   logic [CW-1:0]         offset;
   logic                  issue_ok;
   logic                  move;

   // circular slot of head plus an offset below depth
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, off};
      if (sum >= (CW + 1)'(DEPTH)) begin
         sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign cmd       = rde_pkg::cmd_type'(req_command);

   assign offset   = rev_ff ? (count_ff - CW'(1) - issue_ff) : issue_ff;
   assign issue_ok = (state_ff == ST_STREAM) && (issue_ff != count_ff) &&
                     (!pend_ff || out_free);
   assign move     = (state_ff == ST_STREAM) && pend_ff && out_free;

   assign wr_addr = slot_of(head_ff, count_ff);
   assign wr_data = req_value;
   assign rd_addr = slot_of(head_ff, offset);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      rev_in         = rev_ff;
      err_in         = err_ff;
      issue_in       = issue_ff;
      pend_in        = pend_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_element_in = rsp_element_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      mem_ctl        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  rde_pkg::CMD_LOAD: begin
                     if (!err_ff) begin
                        if (count_ff == CW'(DEPTH)) begin
                           rsp_valid_in   = 1'b1;
                           rsp_element_in = '0;
                           rsp_kind_in    = rde_pkg::KIND_FULL;
                           rsp_last_in    = 1'b1;
                        end else begin
                           mem_ctl.wr_en = 1'b1;
                           count_in      = count_ff + CW'(1);
                        end
                     end
                  end
                  rde_pkg::CMD_REVERSE: begin
                     if (!err_ff) begin
                        rev_in = !rev_ff;
                     end
                  end
                  rde_pkg::CMD_DELETE: begin
                     if (!err_ff) begin
                        if (count_ff == '0) begin
                           err_in = 1'b1;
                        end else begin
                           if (!rev_ff) begin
                              head_in = slot_of(head_ff, CW'(1));
                           end
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  rde_pkg::CMD_FINISH: begin
                     if (err_ff || (count_ff == '0)) begin
                        rsp_valid_in   = 1'b1;
                        rsp_element_in = '0;
                        rsp_kind_in    = err_ff ? rde_pkg::KIND_ERROR : rde_pkg::KIND_EMPTY;
                        rsp_last_in    = 1'b1;
                        head_in        = '0;
                        count_in       = '0;
                        rev_in         = 1'b0;
                        err_in         = 1'b0;
                     end else begin
                        state_in = ST_STREAM;
                        issue_in = '0;
                        pend_in  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STREAM: begin
            if (move) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = rd_data;
               rsp_kind_in    = rde_pkg::KIND_ELEMENT;
               rsp_last_in    = pend_last_ff;
               pend_in        = 1'b0;
               if (pend_last_ff) begin
                  state_in = ST_IDLE;
                  head_in  = '0;
                  count_in = '0;
                  rev_in   = 1'b0;
                  err_in   = 1'b0;
               end
            end
            if (issue_ok) begin
               mem_ctl.rd_en = 1'b1;
               issue_in      = issue_ff + CW'(1);
               pend_in       = 1'b1;
               pend_last_in  = (issue_ff + CW'(1)) == count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         err_ff       <= 1'b0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         err_ff       <= err_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_element_ff <= rsp_element_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

@@ sv/reversible_deque_engine.sv @@
// ----------------------------------------------------------------------------
// reversible_deque_engine
// Load, reverse and delete are each handled on acceptance; a full-store beat
// is offered in the cycle after acceptance at the earliest.
// Finish streams the list at one beat per cycle while result beats are taken;
// its first beat passes the stream state, the memory read register and the
// result register.
// No command is taken while a finish is streaming or a result beat is stalled.
// Synchronous active-high reset clears pointers, flags and the result valid;
// the element memory is not cleared.
// ----------------------------------------------------------------------------
module reversible_deque_engine #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic [VALUE_BITS-1:0]   req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [VALUE_BITS-1:0]   rsp_element,
   output logic [1:0]              rsp_kind,
   output logic                    rsp_last
);

   localparam int AW = $clog2(DEPTH);

   rde_pkg::mem_ctl_type  mem_ctl;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   rde_ctrl #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_element (rsp_element),
      .rsp_kind    (rsp_kind),
      .rsp_last    (rsp_last),
      .mem_ctl     (mem_ctl),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   rde_store #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status beats carry a zero element and close their run
   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != rde_pkg::KIND_ELEMENT)) |-> (rsp_element == '0) && rsp_last)
      else $error("status beat with element or without last");

   // a command is taken only when the result register can take its beat
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("command taken while result beat stalled");

   // memory writes come only from an accepted load
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (req_valid && req_ready &&
                         (req_command == rde_pkg::CMD_LOAD)))
      else $error("store write without accepted load");

   // streaming reads never overlap command writes
   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |-> (!mem_ctl.wr_en && !req_ready))
      else $error("store read overlaps command handling");

endmodule
